[sv/qph_pkg.sv]
// ============================================================================
// qph_pkg
// Shared types, constants and helpers of the quadratic probing hash table.
// ============================================================================
package qph_pkg;

    localparam int TABLE_SIZE      = 16;
    localparam int IDX_BITS        = $clog2(TABLE_SIZE);
    localparam int KEY_BITS        = 32;
    localparam int SEARCH_KEY_BITS = 32;
    localparam int VALUE_BITS      = 32;
    localparam int SLOT_BITS       = 4;
    localparam int STATUS_BITS     = 2;
    localparam int COEF_BITS       = 8;
    localparam int CFG_INDEX_BITS  = 8;
    localparam int ENTRY_BITS      = KEY_BITS + VALUE_BITS;

    localparam int S_TDATA_BITS = ((SEARCH_KEY_BITS + VALUE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((VALUE_BITS + SLOT_BITS + 7) / 8) * 8;

    localparam logic [COEF_BITS-1:0] LINEAR_COEF_RESET = COEF_BITS'(5);
    localparam logic [COEF_BITS-1:0] SQUARE_COEF_RESET = COEF_BITS'(7);

    localparam logic [CFG_INDEX_BITS-1:0] CFG_LINEAR_IDX = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SQUARE_IDX = CFG_INDEX_BITS'(1);

    localparam logic [STATUS_BITS-1:0] STATUS_OK        = STATUS_BITS'(0);
    localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = STATUS_BITS'(1);
    localparam logic [STATUS_BITS-1:0] STATUS_FULL      = STATUS_BITS'(2);

    localparam logic [VALUE_BITS-1:0] VALUE_MISS = '1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PROBE = 4'b0010,
        ST_CHECK = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    typedef struct packed {
        logic start;
        logic advance;
    } probe_cmd_t;

    // Sum of two slot indexes, reduced modulo the table size.
    function automatic logic [IDX_BITS-1:0] mod_add(input logic [IDX_BITS-1:0] a,
                                                    input logic [IDX_BITS-1:0] b);
        logic [IDX_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (IDX_BITS+1)'(TABLE_SIZE)) begin
            sum = sum - (IDX_BITS+1)'(TABLE_SIZE);
        end
        return sum[IDX_BITS-1:0];
    endfunction

endpackage

[sv/quadratic_probe_hash_table_top.sv]
// ============================================================================
// quadratic_probe_hash_table_top
// Open-addressing key/value store with quadratic probing over a table RAM.
// ============================================================================
// Each probe reads the table RAM in ST_PROBE and compares the entry in ST_CHECK.
// A request makes 1 to 16 probes; its result word is loaded into the output
// register from ST_DONE, and a new word is accepted only back in ST_IDLE.
// A result word still waiting in the output register holds the next one back.
// Synchronous active-low reset clears all slot valid bits at once, restores
// the probe coefficients to 5 and 7, and empties the output register.
module quadratic_probe_hash_table_top
    import qph_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [S_TDATA_BITS-1:0]   s_tdata,   // search_key, write_value
    input  logic                      s_tuser,   // req_type
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [M_TDATA_BITS-1:0]   m_tdata,   // read_value, slot_index, zero pad
    output logic [STATUS_BITS-1:0]    m_tuser,   // status
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COEF_BITS-1:0]      cfg_data
);

    state_t                  state_reg;
    state_t                  state_next;
    logic                    req_insert_reg;
    logic [KEY_BITS-1:0]     req_key_reg;
    logic [VALUE_BITS-1:0]   req_value_reg;
    logic [COEF_BITS-1:0]    lin_coef_reg;
    logic [COEF_BITS-1:0]    sq_coef_reg;
    logic [TABLE_SIZE-1:0]   slot_valid_reg;
    logic [STATUS_BITS-1:0]  res_status_reg;
    logic [VALUE_BITS-1:0]   res_value_reg;
    logic [IDX_BITS-1:0]     res_slot_reg;
    logic                    m_tvalid_reg;
    logic [STATUS_BITS-1:0]  m_tuser_reg;
    logic [M_TDATA_BITS-1:0] m_tdata_reg;

    logic                    in_fire;
    logic                    out_free;
    logic [KEY_BITS-1:0]     in_key;
    logic [IDX_BITS-1:0]     home;
    probe_cmd_t              probe_cmd;
    logic [IDX_BITS-1:0]     probe_idx;
    logic                    probe_last;
    logic [ENTRY_BITS-1:0]   ram_rdata;
    logic                    ram_we;
    logic [KEY_BITS-1:0]     rd_key;
    logic [VALUE_BITS-1:0]   rd_value;
    logic                    cur_valid;
    logic                    key_match;
    logic                    stop;
    logic                    finish;
    logic [STATUS_BITS-1:0]  res_status;
    logic [VALUE_BITS-1:0]   res_value;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign in_key    = s_tdata[KEY_BITS-1:0];
    assign home      = IDX_BITS'(in_key % TABLE_SIZE);

    assign rd_key    = ram_rdata[KEY_BITS-1:0];
    assign rd_value  = ram_rdata[KEY_BITS +: VALUE_BITS];
    assign cur_valid = slot_valid_reg[probe_idx];
    assign key_match = cur_valid && (rd_key == req_key_reg);
    assign stop      = !cur_valid || key_match;
    assign finish    = (state_reg == ST_CHECK) && (stop || probe_last);
    assign ram_we    = (state_reg == ST_CHECK) && stop && req_insert_reg;

    assign probe_cmd.start   = in_fire;
    assign probe_cmd.advance = (state_reg == ST_CHECK) && !stop && !probe_last;

    qph_probe_gen u_probe_gen (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (probe_cmd),
        .home     (home),
        .lin_coef (lin_coef_reg),
        .sq_coef  (sq_coef_reg),
        .idx      (probe_idx),
        .last     (probe_last)
    );

    qph_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (TABLE_SIZE)
    ) u_table_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (probe_idx),
        .wdata ({req_value_reg, req_key_reg}),
        .raddr (probe_idx),
        .rdata (ram_rdata)
    );

    always_comb begin
        if (req_insert_reg) begin
            res_status = stop ? STATUS_OK : STATUS_FULL;
            res_value  = '0;
        end else if (key_match) begin
            res_status = STATUS_OK;
            res_value  = rd_value;
        end else begin
            res_status = STATUS_NOT_FOUND;
            res_value  = VALUE_MISS;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = finish ? ST_DONE : ST_PROBE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            req_insert_reg <= s_tuser;
            req_key_reg    <= in_key;
            req_value_reg  <= s_tdata[SEARCH_KEY_BITS +: VALUE_BITS];
        end
        if (finish) begin
            res_status_reg <= res_status;
            res_value_reg  <= res_value;
            res_slot_reg   <= probe_idx;
        end
        if (state_reg == ST_DONE && out_free) begin
            m_tuser_reg <= res_status_reg;
            m_tdata_reg <= M_TDATA_BITS'({SLOT_BITS'(res_slot_reg), res_value_reg});
        end
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            slot_valid_reg <= '0;
            lin_coef_reg   <= LINEAR_COEF_RESET;
            sq_coef_reg    <= SQUARE_COEF_RESET;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (ram_we) begin
                slot_valid_reg[probe_idx] <= 1'b1;
            end
            if (cfg_valid && cfg_index == CFG_LINEAR_IDX) begin
                lin_coef_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == CFG_SQUARE_IDX) begin
                sq_coef_reg <= cfg_data;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    a_store_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK && ram_we) |=> slot_valid_reg[$past(probe_idx)])
        else $error("Stored slot is not marked valid.");

    a_empty_slot_ends_search: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK && !cur_valid) |=> (state_reg == ST_DONE))
        else $error("Probing continued past an empty slot.");

    a_lookup_never_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !req_insert_reg) |-> (res_status_reg != STATUS_FULL))
        else $error("Lookup reported a full table.");

    a_full_has_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg == STATUS_FULL)
            |-> (m_tdata_reg[VALUE_BITS-1:0] == '0))
        else $error("Failed insert returned a nonzero value.");

endmodule

[sv/qph_ram.sv]
// ============================================================================
// qph_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module qph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/qph_probe_gen.sv]
// ============================================================================
// qph_probe_gen
// Probe slot sequencer using finite differences of the quadratic offset.
// ============================================================================
module qph_probe_gen
    import qph_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  probe_cmd_t           cmd,
    input  logic [IDX_BITS-1:0]  home,
    input  logic [COEF_BITS-1:0] lin_coef,
    input  logic [COEF_BITS-1:0] sq_coef,
    output logic [IDX_BITS-1:0]  idx,
    output logic                 last
);

    logic [IDX_BITS-1:0] idx_reg;
    logic [IDX_BITS-1:0] idx_next;
    logic [IDX_BITS-1:0] delta_reg;
    logic [IDX_BITS-1:0] delta_next;
    logic [IDX_BITS-1:0] step_reg;
    logic [IDX_BITS-1:0] step_next;
    logic [IDX_BITS-1:0] count_reg;
    logic [IDX_BITS-1:0] count_next;
    logic [IDX_BITS-1:0] lin_mod;
    logic [IDX_BITS-1:0] sq_mod;

    assign lin_mod = IDX_BITS'(lin_coef % TABLE_SIZE);
    assign sq_mod  = IDX_BITS'(sq_coef % TABLE_SIZE);

    // The offset difference between probe i and i+1 is a + b*(2i+1).
    always_comb begin
        idx_next   = idx_reg;
        delta_next = delta_reg;
        step_next  = step_reg;
        count_next = count_reg;
        if (cmd.start) begin
            idx_next   = home;
            delta_next = mod_add(lin_mod, sq_mod);
            step_next  = mod_add(sq_mod, sq_mod);
            count_next = '0;
        end else if (cmd.advance) begin
            idx_next   = mod_add(idx_reg, delta_reg);
            delta_next = mod_add(delta_reg, step_reg);
            count_next = count_reg + IDX_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        delta_reg <= delta_next;
        step_reg  <= step_next;
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign idx  = idx_reg;
    assign last = (count_reg == IDX_BITS'(TABLE_SIZE - 1));

endmodule
